### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL. They expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge while out of reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The condition must never be seen while out of reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

### hdl/pswt_pkg.sv
// ----------------------------------------------------------------------------
// pswt_pkg
// Types and constants for the pixel shadow write-through block.
// ----------------------------------------------------------------------------
package pswt_pkg;

    localparam int COLUMNS_DEF = 128;
    localparam int PAGES_DEF   = 8;

    localparam int BYTE_W = 8;
    localparam int INDEX_W = 2;

    // Configuration register indexes.
    localparam logic [INDEX_W-1:0] REG_PAGE_BASE     = 2'd0;
    localparam logic [INDEX_W-1:0] REG_COL_LOW_BASE  = 2'd1;
    localparam logic [INDEX_W-1:0] REG_COL_HIGH_BASE = 2'd2;

    localparam logic [BYTE_W-1:0] PAGE_BASE_RST     = 8'd176;
    localparam logic [BYTE_W-1:0] COL_LOW_BASE_RST  = 8'd0;
    localparam logic [BYTE_W-1:0] COL_HIGH_BASE_RST = 8'd16;

    typedef struct packed {
        logic [BYTE_W-1:0] page_cmd_base;
        logic [BYTE_W-1:0] col_low_cmd_base;
        logic [BYTE_W-1:0] col_high_cmd_base;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MODIFY,
        ST_COL_LO,
        ST_COL_HI,
        ST_DATA
    } state_t;

endpackage

### hdl/pixel_shadow_write_through.sv
// ----------------------------------------------------------------------------
// pixel_shadow_write_through
// Shadow frame store for a page-addressed monochrome display. A pixel write
// that changes a stored bit emits page, column-low, column-high and data bytes.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake               Payload
// pixel     in         start while !busy       column, row, colour
// bytes     out        strobe, one cycle each  out_byte, is_data, last
// config    in         wr_en, no wait          wr_index, wr_data
//
// After reset a clearing pass writes zero to every store entry, one a cycle:
// 2**(clog2(COLUMNS) + max(clog2(PAGES), 1)) entries, 1024 at the defaults; busy is high.
// A pixel that changes its bit passes from accept to the next accept through the
// read-modify-write step, three byte steps and one idle step. The page byte comes from
// the read-modify-write step and the rest from the byte steps, each one registered.
// An unchanged pixel stops after read-modify-write; an out-of-range pixel is dropped.
// The receiver cannot stall; each byte is valid for exactly one cycle.
//
module pixel_shadow_write_through #(
    parameter int COLUMNS = pswt_pkg::COLUMNS_DEF,
    parameter int PAGES   = pswt_pkg::PAGES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [pswt_pkg::BYTE_W-1:0]  column,
    input  logic [pswt_pkg::BYTE_W-1:0]  row,
    input  logic                         colour,
    output logic                         strobe,
    output logic [pswt_pkg::BYTE_W-1:0]  out_byte,
    output logic                         is_data,
    output logic                         last,
    input  logic                         wr_en,
    input  logic [pswt_pkg::INDEX_W-1:0] wr_index,
    input  logic [pswt_pkg::BYTE_W-1:0]  wr_data
);

    import pswt_pkg::*;

    cfg_t cfg;

    pswt_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    pswt_seq #(
        .COLUMNS (COLUMNS),
        .PAGES   (PAGES)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .start    (start),
        .busy     (busy),
        .column   (column),
        .row      (row),
        .colour   (colour),
        .strobe   (strobe),
        .out_byte (out_byte),
        .is_data  (is_data),
        .last     (last)
    );

endmodule

### hdl/pswt_ram.sv
// ----------------------------------------------------------------------------
// pswt_ram
// Generic RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module pswt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hdl/pswt_cfg.sv
// ----------------------------------------------------------------------------
// pswt_cfg
// Command base registers, written through a plain write port.
// ----------------------------------------------------------------------------
module pswt_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr_en,
    input  logic [pswt_pkg::INDEX_W-1:0] wr_index,
    input  logic [pswt_pkg::BYTE_W-1:0]  wr_data,
    output pswt_pkg::cfg_t               cfg
);

    import pswt_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_PAGE_BASE:     cfg_next.page_cmd_base     = wr_data;
                REG_COL_LOW_BASE:  cfg_next.col_low_cmd_base  = wr_data;
                REG_COL_HIGH_BASE: cfg_next.col_high_cmd_base = wr_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.page_cmd_base     <= PAGE_BASE_RST;
            cfg_reg.col_low_cmd_base  <= COL_LOW_BASE_RST;
            cfg_reg.col_high_cmd_base <= COL_HIGH_BASE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### hdl/pswt_seq.sv
// ----------------------------------------------------------------------------
// pswt_seq
// Read-modify-write sequencer around the frame store, with the clearing
// pass after reset and the four-byte command stream.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pswt_seq #(
    parameter int COLUMNS = pswt_pkg::COLUMNS_DEF,
    parameter int PAGES   = pswt_pkg::PAGES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  pswt_pkg::cfg_t              cfg,
    input  logic                        start,
    output logic                        busy,
    input  logic [pswt_pkg::BYTE_W-1:0] column,
    input  logic [pswt_pkg::BYTE_W-1:0] row,
    input  logic                        colour,
    output logic                        strobe,
    output logic [pswt_pkg::BYTE_W-1:0] out_byte,
    output logic                        is_data,
    output logic                        last
);

    import pswt_pkg::*;

    localparam int CW    = $clog2(COLUMNS);
    localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int AW    = CW + PW;
    localparam int DEPTH = 1 << AW;

    localparam logic [8:0] COL_MAX = 9'(COLUMNS - 1);
    localparam logic [8:0] ROW_MAX = 9'(PAGES * 8 - 1);

    state_t state_reg;
    state_t state_next;

    logic [AW-1:0]     clr_cnt_reg;
    logic [AW-1:0]     clr_cnt_next;
    logic [AW-1:0]     addr_reg;
    logic [AW-1:0]     addr_next;
    logic [BYTE_W-1:0] col_reg;
    logic [BYTE_W-1:0] col_next;
    logic [PW-1:0]     page_reg;
    logic [PW-1:0]     page_next;
    logic [2:0]        bit_reg;
    logic [2:0]        bit_next;
    logic              colour_reg;
    logic              colour_next;
    logic [BYTE_W-1:0] data_reg;
    logic [BYTE_W-1:0] data_next;

    logic              strobe_reg;
    logic              strobe_next;
    logic [BYTE_W-1:0] byte_reg;
    logic [BYTE_W-1:0] byte_next;
    logic              is_data_reg;
    logic              is_data_next;
    logic              last_reg;
    logic              last_next;

    logic              in_range;
    logic              accept;
    logic [AW-1:0]     in_addr;
    logic [BYTE_W-1:0] rd_data;
    logic [BYTE_W-1:0] bit_mask;
    logic [BYTE_W-1:0] new_byte;
    logic              changed;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [BYTE_W-1:0] mem_wdata;

    assign in_range = ({1'b0, column} <= COL_MAX) && ({1'b0, row} <= ROW_MAX);
    assign accept   = start && (state_reg == ST_IDLE);
    assign in_addr  = {column[CW-1:0], row[3 +: PW]};

    assign bit_mask = 8'h01 << bit_reg;
    assign changed  = (rd_data[bit_reg] != colour_reg);
    assign new_byte = colour_reg ? (rd_data | bit_mask) : (rd_data & ~bit_mask);

    pswt_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (in_addr),
        .rdata (rd_data)
    );

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        addr_next    = addr_reg;
        col_next     = col_reg;
        page_next    = page_reg;
        bit_next     = bit_reg;
        colour_next  = colour_reg;
        data_next    = data_reg;
        strobe_next  = 1'b0;
        byte_next    = byte_reg;
        is_data_next = 1'b0;
        last_next    = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = addr_reg;
        mem_wdata    = new_byte;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (&clr_cnt_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                // The store is read straight from the input ports, so the
                // stored byte is ready in the next cycle.
                if (start && in_range)
                begin
                    addr_next   = in_addr;
                    col_next    = column;
                    page_next   = row[3 +: PW];
                    bit_next    = row[2:0];
                    colour_next = colour;
                    state_next  = ST_MODIFY;
                end
            end
            ST_MODIFY:
            begin
                if (changed)
                begin
                    mem_we      = 1'b1;
                    data_next   = new_byte;
                    strobe_next = 1'b1;
                    byte_next   = cfg.page_cmd_base + BYTE_W'(page_reg);
                    state_next  = ST_COL_LO;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_COL_LO:
            begin
                strobe_next = 1'b1;
                byte_next   = cfg.col_low_cmd_base + {4'h0, col_reg[3:0]};
                state_next  = ST_COL_HI;
            end
            ST_COL_HI:
            begin
                strobe_next = 1'b1;
                byte_next   = cfg.col_high_cmd_base + {4'h0, col_reg[7:4]};
                state_next  = ST_DATA;
            end
            ST_DATA:
            begin
                strobe_next  = 1'b1;
                byte_next    = data_reg;
                is_data_next = 1'b1;
                last_next    = 1'b1;
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            strobe_reg  <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg    <= addr_next;
        col_reg     <= col_next;
        page_reg    <= page_next;
        bit_reg     <= bit_next;
        colour_reg  <= colour_next;
        data_reg    <= data_next;
        byte_reg    <= byte_next;
        is_data_reg <= is_data_next;
        last_reg    <= last_next;
    end

    assign busy     = (state_reg != ST_IDLE);
    assign strobe   = strobe_reg;
    assign out_byte = byte_reg;
    assign is_data  = is_data_reg;
    assign last     = last_reg;

    `ASSERT_PROP(a_accept_to_modify, clk, rst_n, accept && in_range |=> state_reg == ST_MODIFY, "in-range item did not start a store access")
    `ASSERT_PROP(a_last_after_data, clk, rst_n, strobe_reg && last_reg |-> $past(state_reg) == ST_DATA, "last byte not issued from the data step")
    `ASSERT_PROP(a_write_only_on_change, clk, rst_n, mem_we && state_reg != ST_CLEAR |-> state_reg == ST_MODIFY && changed, "store written outside a changed pixel")
    `ASSERT_PROP(a_first_byte_is_command, clk, rst_n, state_reg == ST_COL_LO |-> strobe_reg && !is_data_reg, "page command missing before column commands")

endmodule

### tb/sv/pixel_shadow_write_through_test.sv
`timescale 1ns / 100ps

// ----------------------------------------------------------------------------
// pixel_shadow_write_through_test
// Drives pixel writes and command base settings into the shadow frame store,
// keeps its own copy of the store and the bases, and checks every emitted
// controller byte against the bytes that copy says should come out.
// ----------------------------------------------------------------------------
module pixel_shadow_write_through_test;
    import pswt_pkg::*;

    localparam int COLUMNS       = COLUMNS_DEF;
    localparam int PAGES         = PAGES_DEF;
    localparam int STALL_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 8;

    // Index past the end of the register list; writes to it must be ignored.
    localparam logic [INDEX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              is_data;
        logic              last;
    } ctrl_byte_t;

    class display_byte_tracker;
        logic [BYTE_W-1:0] shadow [COLUMNS*PAGES];
        logic [BYTE_W-1:0] page_base;
        logic [BYTE_W-1:0] col_low_base;
        logic [BYTE_W-1:0] col_high_base;
        ctrl_byte_t        expected_bytes [$];
        int                errors;

        function new();
            foreach (shadow[i])
                shadow[i] = '0;
            page_base     = PAGE_BASE_RST;
            col_low_base  = COL_LOW_BASE_RST;
            col_high_base = COL_HIGH_BASE_RST;
            errors        = 0;
        endfunction

        function void write_reg(logic [INDEX_W-1:0] index, logic [BYTE_W-1:0] value);
            case (index)
                REG_PAGE_BASE:     page_base     = value;
                REG_COL_LOW_BASE:  col_low_base  = value;
                REG_COL_HIGH_BASE: col_high_base = value;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction

        function void note_pixel(logic [BYTE_W-1:0] px_col, logic [BYTE_W-1:0] px_row,
                                 logic px_colour);
            int                page;
            int                bit_pos;
            int                idx;
            logic [BYTE_W-1:0] cur;
            ctrl_byte_t        b;
            if (px_col > COLUMNS - 1 || px_row > PAGES * 8 - 1)
                return;
            page    = px_row >> 3;
            bit_pos = px_row & 7;
            idx     = px_col * PAGES + page;
            cur     = shadow[idx];
            // A pixel that already shows the requested colour sends nothing.
            if (cur[bit_pos] == px_colour)
                return;
            cur[bit_pos] = px_colour;
            shadow[idx]  = cur;
            b.is_data    = 1'b0;
            b.last       = 1'b0;
            b.out_byte   = BYTE_W'(page_base + page);
            expected_bytes.push_back(b);
            b.out_byte   = BYTE_W'(col_low_base + px_col[3:0]);
            expected_bytes.push_back(b);
            b.out_byte   = BYTE_W'(col_high_base + px_col[7:4]);
            expected_bytes.push_back(b);
            b.out_byte   = cur;
            b.is_data    = 1'b1;
            b.last       = 1'b1;
            expected_bytes.push_back(b);
        endfunction

        function void check_byte(logic [BYTE_W-1:0] got_byte, logic got_is_data,
                                 logic got_last);
            ctrl_byte_t want;
            if (expected_bytes.size() == 0)
            begin
                $error("unexpected byte: out_byte %02h is_data %0b last %0b",
                       got_byte, got_is_data, got_last);
                errors++;
                return;
            end
            want = expected_bytes.pop_front();
            if (got_byte !== want.out_byte)
            begin
                $error("out_byte: expected %02h, got %02h", want.out_byte, got_byte);
                errors++;
            end
            if (got_is_data !== want.is_data)
            begin
                $error("is_data: expected %0b, got %0b", want.is_data, got_is_data);
                errors++;
            end
            if (got_last !== want.last)
            begin
                $error("last: expected %0b, got %0b", want.last, got_last);
                errors++;
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [BYTE_W-1:0]   column;
    logic [BYTE_W-1:0]   row;
    logic                colour;
    logic                strobe;
    logic [BYTE_W-1:0]   out_byte;
    logic                is_data;
    logic                last;
    logic                wr_en;
    logic [INDEX_W-1:0]  wr_index;
    logic [BYTE_W-1:0]   wr_data;

    display_byte_tracker tracker;
    int                  gap_pct;
    int                  stall_count;

    pixel_shadow_write_through i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .column   (column),
        .row      (row),
        .colour   (colour),
        .strobe   (strobe),
        .out_byte (out_byte),
        .is_data  (is_data),
        .last     (last),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        if (rst_n && strobe)
            tracker.check_byte(out_byte, is_data, last);
    end

    // Ends the run if neither an item nor a byte moves for too long.
    always @(posedge clk)
    begin
        if ((start && !busy) || strobe)
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count >= STALL_LIMIT)
        begin
            $display("** pixel_shadow_write_through: FAILED **");
            $finish;
        end
    end

    // Offers one pixel until it is taken, idling in about gap_pct percent of cycles.
    task automatic send_pixel(input logic [BYTE_W-1:0] px_col, input logic [BYTE_W-1:0] px_row,
                              input logic px_colour);
        logic taken;
        taken  = 1'b0;
        column <= px_col;
        row    <= px_row;
        colour <= px_colour;
        while (!taken)
        begin
            if ($urandom_range(0, 99) < gap_pct)
                start <= 1'b0;
            else
                start <= 1'b1;
            @(posedge clk);
            taken = start && !busy;
        end
        tracker.note_pixel(px_col, px_row, px_colour);
    endtask

    // Unchanged pixels send nothing, so the settling wait after the drain covers one in flight.
    task automatic drain_and_settle();
        start <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_bases(input logic [BYTE_W-1:0] page_b,
                                 input logic [BYTE_W-1:0] low_b,
                                 input logic [BYTE_W-1:0] high_b);
        logic [BYTE_W-1:0] junk;
        junk     = BYTE_W'($urandom_range(0, 255));
        wr_en    <= 1'b1;
        wr_index <= REG_PAGE_BASE;
        wr_data  <= page_b;
        @(posedge clk);
        wr_index <= REG_COL_LOW_BASE;
        wr_data  <= low_b;
        @(posedge clk);
        wr_index <= REG_COL_HIGH_BASE;
        wr_data  <= high_b;
        @(posedge clk);
        wr_index <= REG_UNUSED;
        wr_data  <= junk;
        @(posedge clk);
        wr_en    <= 1'b0;
        tracker.write_reg(REG_PAGE_BASE, page_b);
        tracker.write_reg(REG_COL_LOW_BASE, low_b);
        tracker.write_reg(REG_COL_HIGH_BASE, high_b);
        tracker.write_reg(REG_UNUSED, junk);
    endtask

    // Mostly in-range writes, many into a small corner so bits toggle back and
    // forth and repeats hit the unchanged case; the rest is full-range noise.
    task automatic random_pixels(input int count, input int pct);
        int                sel;
        logic [BYTE_W-1:0] px_col;
        logic [BYTE_W-1:0] px_row;
        gap_pct = pct;
        repeat (count)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 10)
            begin
                px_col = BYTE_W'($urandom_range(0, 255));
                px_row = BYTE_W'($urandom_range(0, 255));
            end
            else if (sel < 45)
            begin
                px_col = BYTE_W'($urandom_range(0, 3));
                px_row = BYTE_W'($urandom_range(0, 15));
            end
            else
            begin
                px_col = BYTE_W'($urandom_range(0, COLUMNS - 1));
                px_row = BYTE_W'($urandom_range(0, PAGES * 8 - 1));
            end
            send_pixel(px_col, px_row, 1'($urandom_range(0, 1)));
        end
    endtask

    initial
    begin
        tracker     = new();
        rst_n       = 1'b0;
        start       = 1'b0;
        column      = '0;
        row         = '0;
        colour      = 1'b0;
        wr_en       = 1'b0;
        wr_index    = '0;
        wr_data     = '0;
        gap_pct     = 11;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Reset bases: corners, repeats, out-of-range points, set and clear.
        send_pixel(8'd0, 8'd0, 1'b1);
        send_pixel(8'd0, 8'd0, 1'b1);
        send_pixel(8'd127, 8'd63, 1'b1);
        send_pixel(8'd128, 8'd0, 1'b1);
        send_pixel(8'd0, 8'd64, 1'b1);
        send_pixel(8'd255, 8'd255, 1'b1);
        send_pixel(8'd0, 8'd0, 1'b0);
        send_pixel(8'd0, 8'd0, 1'b0);
        send_pixel(8'd127, 8'd63, 1'b0);
        send_pixel(8'h55, 8'h2A, 1'b1);
        send_pixel(8'hAA, 8'h15, 1'b1);
        send_pixel(8'd42, 8'd21, 1'b1);
        drain_and_settle();

        // Every base at its maximum, so a command byte wraps whenever its offset is not zero.
        program_bases(8'hFF, 8'hFF, 8'hFF);
        send_pixel(8'd127, 8'd63, 1'b1);
        send_pixel(8'd16, 8'd8, 1'b1);
        send_pixel(8'd0, 8'd0, 1'b1);
        send_pixel(8'd127, 8'd62, 1'b1);
        drain_and_settle();

        program_bases(8'h00, 8'h00, 8'h00);
        send_pixel(8'd127, 8'd56, 1'b1);
        send_pixel(8'd1, 8'd1, 1'b1);
        send_pixel(8'd64, 8'd32, 1'b1);
        send_pixel(8'd64, 8'd32, 1'b0);
        send_pixel(8'd64, 8'd32, 1'b0);
        drain_and_settle();

        program_bases(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)),
                      BYTE_W'($urandom_range(0, 255)));
        random_pixels(95, 11);
        drain_and_settle();

        program_bases(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)),
                      BYTE_W'($urandom_range(0, 255)));
        random_pixels(95, 49);
        drain_and_settle();

        program_bases(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)),
                      BYTE_W'($urandom_range(0, 255)));
        random_pixels(100, 0);
        drain_and_settle();
        repeat (20) @(posedge clk);

        if (tracker.errors == 0)
            $display("** pixel_shadow_write_through: PASSED **");
        else
            $display("** pixel_shadow_write_through: FAILED **");
        $finish;
    end

endmodule
